FILE: rtl/tcpd_pkg.sv
package tcpd_pkg;

    localparam int QUEUE_DEPTH    = 128;
    localparam int URGENCY_LEVELS = 3;

    localparam int RING_COUNT  = URGENCY_LEVELS + 1;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int RING_W      = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
    localparam int SLOT_DEPTH  = RING_COUNT * QUEUE_DEPTH;
    localparam int SLOT_ADDR_W = $clog2(SLOT_DEPTH);
    localparam int UTOT_W      = $clog2(URGENCY_LEVELS * QUEUE_DEPTH + 1);

    localparam int OP_W      = 2;
    localparam int ID_W      = 31;
    localparam int AGE_W     = 32;
    localparam int LEVEL_W   = 3;
    localparam int ENTRY_W   = ID_W + AGE_W;
    localparam int STATUS_W  = 3;
    localparam int SLEVEL_W  = 2;
    localparam int UWAIT_W   = 9;
    localparam int NWAIT_W   = 8;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 88;

    localparam logic [OP_W-1:0] OP_ENQ_NORMAL = 2'd0;
    localparam logic [OP_W-1:0] OP_ENQ_URGENT = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_ADDED         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SERVED_URGENT = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SERVED_NORMAL = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY         = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL          = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_BAD_LEVEL     = 3'd5;

    typedef logic [PTR_W-1:0]       ptr_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [RING_W-1:0]      ring_t;
    typedef logic [SLOT_ADDR_W-1:0] slot_addr_t;

    function automatic ptr_t ptr_advance(input ptr_t p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic slot_addr_t slot_addr(input ring_t r, input ptr_t p);
        return SLOT_ADDR_W'(r) * SLOT_ADDR_W'(QUEUE_DEPTH) + SLOT_ADDR_W'(p);
    endfunction

endpackage

FILE: rtl/tcpd_slot_ram.sv
module tcpd_slot_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 63
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     wr_en,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/two_class_priority_dispatcher_top.sv
// Strict-priority dispatcher with one FIFO ring per class (normal plus urgent
// levels 1..3, level 1 served first). The request is decoded and the ring
// slot is written or read in the accept cycle, and the result is formed from
// the slot RAM's registered read data once the output register is free. All
// rings share one single-port slot RAM, so one access per word sets the rate;
// s_tready stays low while a word is pending, and a finished word waits in the
// output register without blocking the next request unless a second result
// would have to queue behind it. Full rings and bad levels are refused with a
// status and leave the queues unchanged. Slot contents are not cleared at
// reset; ring pointers and depths are.
module two_class_priority_dispatcher_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_id, entry_age_bits, urgency_level, zero pad
    input  logic [tcpd_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [tcpd_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // served_id, served_age_bits, served_level, urgent_waiting,
    // normal_waiting, zero pad
    output logic [tcpd_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [tcpd_pkg::STATUS_W-1:0]    m_tuser
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_PEND = 1'b1;

    localparam int LVL_LO = tcpd_pkg::ID_W + tcpd_pkg::AGE_W;

    logic st_reg, st_next;

    tcpd_pkg::ptr_t head_reg [tcpd_pkg::RING_COUNT];
    tcpd_pkg::ptr_t head_next[tcpd_pkg::RING_COUNT];
    tcpd_pkg::ptr_t tail_reg [tcpd_pkg::RING_COUNT];
    tcpd_pkg::ptr_t tail_next[tcpd_pkg::RING_COUNT];
    tcpd_pkg::cnt_t cnt_reg  [tcpd_pkg::RING_COUNT];
    tcpd_pkg::cnt_t cnt_next [tcpd_pkg::RING_COUNT];
    logic [tcpd_pkg::UTOT_W-1:0] utot_reg, utot_next;

    logic [tcpd_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [tcpd_pkg::SLEVEL_W-1:0] pend_level_reg, pend_level_next;
    logic                          pend_serve_reg, pend_serve_next;

    logic                          out_valid_reg, out_valid_next;
    logic [tcpd_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [tcpd_pkg::ID_W-1:0]     out_id_reg, out_id_next;
    logic [tcpd_pkg::AGE_W-1:0]    out_age_reg, out_age_next;
    logic [tcpd_pkg::SLEVEL_W-1:0] out_level_reg, out_level_next;
    logic [tcpd_pkg::UWAIT_W-1:0]  out_uwait_reg, out_uwait_next;
    logic [tcpd_pkg::NWAIT_W-1:0]  out_nwait_reg, out_nwait_next;

    logic [tcpd_pkg::OP_W-1:0]    in_op;
    logic [tcpd_pkg::ID_W-1:0]    in_id;
    logic [tcpd_pkg::AGE_W-1:0]   in_age;
    logic [tcpd_pkg::LEVEL_W-1:0] in_level;

    logic                 accept;
    logic                 is_deq;
    logic                 level_ok;
    logic                 enq_full;
    tcpd_pkg::ring_t      enq_ring;
    logic                 found_urg;
    tcpd_pkg::ring_t      urg_ring;
    tcpd_pkg::ring_t      deq_ring;
    logic                 deq_hit;
    logic                 do_write;
    logic                 do_read;
    logic                 out_free;
    tcpd_pkg::slot_addr_t ram_addr;
    logic [tcpd_pkg::ENTRY_W-1:0] ram_rd_data;

    assign in_op    = s_tuser;
    assign in_id    = s_tdata[tcpd_pkg::ID_W-1:0];
    assign in_age   = s_tdata[LVL_LO-1:tcpd_pkg::ID_W];
    assign in_level = s_tdata[LVL_LO+tcpd_pkg::LEVEL_W-1:LVL_LO];

    assign s_tready = (st_reg == S_IDLE) && aresetn;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        is_deq   = in_op[tcpd_pkg::OP_W-1];
        level_ok = (in_level != '0) && (int'(in_level) <= tcpd_pkg::URGENCY_LEVELS);
        enq_ring = (in_op == tcpd_pkg::OP_ENQ_URGENT) ? tcpd_pkg::RING_W'(in_level) : '0;
        enq_full = (cnt_reg[enq_ring] == tcpd_pkg::CNT_W'(tcpd_pkg::QUEUE_DEPTH));

        found_urg = 1'b0;
        urg_ring  = '0;
        for (int r = tcpd_pkg::URGENCY_LEVELS; r >= 1; r--) begin
            if (cnt_reg[r] != '0) begin
                found_urg = 1'b1;
                urg_ring  = tcpd_pkg::RING_W'(r);
            end
        end
        deq_hit  = found_urg || (cnt_reg[0] != '0);
        deq_ring = found_urg ? urg_ring : '0;

        do_write = accept && !is_deq && !enq_full
                   && ((in_op == tcpd_pkg::OP_ENQ_NORMAL) || level_ok);
        do_read  = accept && is_deq && deq_hit;
        ram_addr = is_deq ? tcpd_pkg::slot_addr(deq_ring, head_reg[deq_ring])
                          : tcpd_pkg::slot_addr(enq_ring, tail_reg[enq_ring]);
    end

    tcpd_slot_ram #(
        .DEPTH (tcpd_pkg::SLOT_DEPTH),
        .WIDTH (tcpd_pkg::ENTRY_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .addr    (ram_addr),
        .wr_en   (do_write),
        .wr_data ({in_id, in_age}),
        .rd_en   (do_read),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        st_next          = st_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cnt_next         = cnt_reg;
        utot_next        = utot_reg;
        pend_status_next = pend_status_reg;
        pend_level_next  = pend_level_reg;
        pend_serve_next  = pend_serve_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_age_next     = out_age_reg;
        out_level_next   = out_level_reg;
        out_uwait_next   = out_uwait_reg;
        out_nwait_next   = out_nwait_reg;

        if (accept) begin
            st_next         = S_PEND;
            pend_level_next = '0;
            pend_serve_next = 1'b0;
            if (is_deq) begin
                if (deq_hit) begin
                    pend_status_next   = found_urg ? tcpd_pkg::STAT_SERVED_URGENT
                                                   : tcpd_pkg::STAT_SERVED_NORMAL;
                    pend_level_next    = tcpd_pkg::SLEVEL_W'(deq_ring);
                    pend_serve_next    = 1'b1;
                    head_next[deq_ring] = tcpd_pkg::ptr_advance(head_reg[deq_ring]);
                    cnt_next[deq_ring]  = cnt_reg[deq_ring] - 1'b1;
                    if (found_urg) begin
                        utot_next = utot_reg - 1'b1;
                    end
                end else begin
                    pend_status_next = tcpd_pkg::STAT_EMPTY;
                end
            end else if ((in_op == tcpd_pkg::OP_ENQ_URGENT) && !level_ok) begin
                pend_status_next = tcpd_pkg::STAT_BAD_LEVEL;
            end else if (enq_full) begin
                pend_status_next = tcpd_pkg::STAT_FULL;
            end else begin
                pend_status_next    = tcpd_pkg::STAT_ADDED;
                tail_next[enq_ring] = tcpd_pkg::ptr_advance(tail_reg[enq_ring]);
                cnt_next[enq_ring]  = cnt_reg[enq_ring] + 1'b1;
                if (enq_ring != '0) begin
                    utot_next = utot_reg + 1'b1;
                end
            end
        end

        if ((st_reg == S_PEND) && out_free) begin
            st_next         = S_IDLE;
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_level_next  = pend_level_reg;
            out_id_next     = pend_serve_reg ? ram_rd_data[tcpd_pkg::ENTRY_W-1:tcpd_pkg::AGE_W]
                                             : '0;
            out_age_next    = pend_serve_reg ? ram_rd_data[tcpd_pkg::AGE_W-1:0] : '0;
            out_uwait_next  = tcpd_pkg::UWAIT_W'(utot_reg);
            out_nwait_next  = tcpd_pkg::NWAIT_W'(cnt_reg[0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_IDLE;
            out_valid_reg <= 1'b0;
            utot_reg      <= '0;
            for (int r = 0; r < tcpd_pkg::RING_COUNT; r++) begin
                head_reg[r] <= '0;
                tail_reg[r] <= '0;
                cnt_reg[r]  <= '0;
            end
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            utot_reg      <= utot_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_status_reg <= pend_status_next;
        pend_level_reg  <= pend_level_next;
        pend_serve_reg  <= pend_serve_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_age_reg     <= out_age_next;
        out_level_reg   <= out_level_next;
        out_uwait_reg   <= out_uwait_next;
        out_nwait_reg   <= out_nwait_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = tcpd_pkg::M_TDATA_W'({out_nwait_reg, out_uwait_reg, out_level_reg,
                                            out_age_reg, out_id_reg});

    a_depth_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(utot_reg) && $stable(cnt_reg[0]))
        else $error("queue depth changed without a request");

    a_normal_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= tcpd_pkg::CNT_W'(tcpd_pkg::QUEUE_DEPTH))
        else $error("normal ring over capacity");

    a_empty_means_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == tcpd_pkg::STAT_EMPTY)
        |-> (out_uwait_reg == '0) && (out_nwait_reg == '0))
        else $error("empty status with entries waiting");

    a_urgent_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == tcpd_pkg::STAT_SERVED_URGENT) |-> (out_level_reg != '0))
        else $error("urgent service without a level");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [tcpd_pkg::OP_W-1:0] OP_DEQUEUE     = 2'd2;
    localparam logic [tcpd_pkg::OP_W-1:0] OP_DEQUEUE_ALT = 2'd3;
    localparam int HOLD_CYCLES = 300;

    typedef logic [tcpd_pkg::ENTRY_W-1:0] entry_t;

    typedef struct {
        logic [tcpd_pkg::OP_W-1:0]    op;
        logic [tcpd_pkg::ID_W-1:0]    id;
        logic [tcpd_pkg::AGE_W-1:0]   age;
        logic [tcpd_pkg::LEVEL_W-1:0] level;
        int unsigned                  gap;
    } req_t;

    typedef struct {
        logic [tcpd_pkg::STATUS_W-1:0] status;
        logic [tcpd_pkg::ID_W-1:0]     sid;
        logic [tcpd_pkg::AGE_W-1:0]    sage;
        logic [tcpd_pkg::SLEVEL_W-1:0] slevel;
        logic [tcpd_pkg::UWAIT_W-1:0]  uwait;
        logic [tcpd_pkg::NWAIT_W-1:0]  nwait;
    } result_t;

    // m_tdata layout, lowest bits last
    typedef struct packed {
        logic [tcpd_pkg::NWAIT_W-1:0]  nwait;
        logic [tcpd_pkg::UWAIT_W-1:0]  uwait;
        logic [tcpd_pkg::SLEVEL_W-1:0] slevel;
        logic [tcpd_pkg::AGE_W-1:0]    sage;
        logic [tcpd_pkg::ID_W-1:0]     sid;
    } m_word_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tcpd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [tcpd_pkg::OP_W-1:0]      s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tcpd_pkg::M_TDATA_W-1:0] m_tdata;
    logic [tcpd_pkg::STATUS_W-1:0]  m_tuser;

    req_t        req_fifo[$];
    result_t     due_results[$];
    entry_t      model_rings[tcpd_pkg::RING_COUNT][$];
    req_t        cur_req;
    int unsigned lead_cnt   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_total    = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_mark  = 0;
    int unsigned sink_stall = 0;
    int unsigned errors     = 0;

    two_class_priority_dispatcher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [tcpd_pkg::STATUS_W-1:0] ring_push(input int r,
                                                                input entry_t e);
        if (model_rings[r].size() >= tcpd_pkg::QUEUE_DEPTH) return tcpd_pkg::STAT_FULL;
        model_rings[r].push_back(e);
        return tcpd_pkg::STAT_ADDED;
    endfunction

    function automatic result_t predict_dispatch(input req_t rq);
        result_t     rs;
        entry_t      e;
        int unsigned utot;
        rs = '{default: '0};
        utot = 0;
        if (rq.op == tcpd_pkg::OP_ENQ_NORMAL) begin
            rs.status = ring_push(0, {rq.id, rq.age});
        end else if (rq.op == tcpd_pkg::OP_ENQ_URGENT) begin
            if (rq.level < 1 || rq.level > tcpd_pkg::URGENCY_LEVELS) begin
                rs.status = tcpd_pkg::STAT_BAD_LEVEL;
            end else begin
                rs.status = ring_push(int'(rq.level), {rq.id, rq.age});
            end
        end else begin
            rs.status = tcpd_pkg::STAT_EMPTY;
            for (int r = 1; r < tcpd_pkg::RING_COUNT; r++) begin
                if (rs.status == tcpd_pkg::STAT_EMPTY && model_rings[r].size() != 0) begin
                    e = model_rings[r].pop_front();
                    rs.status = tcpd_pkg::STAT_SERVED_URGENT;
                    rs.sid    = e[tcpd_pkg::ENTRY_W-1:tcpd_pkg::AGE_W];
                    rs.sage   = e[tcpd_pkg::AGE_W-1:0];
                    rs.slevel = tcpd_pkg::SLEVEL_W'(r);
                end
            end
            if (rs.status == tcpd_pkg::STAT_EMPTY && model_rings[0].size() != 0) begin
                e = model_rings[0].pop_front();
                rs.status = tcpd_pkg::STAT_SERVED_NORMAL;
                rs.sid    = e[tcpd_pkg::ENTRY_W-1:tcpd_pkg::AGE_W];
                rs.sage   = e[tcpd_pkg::AGE_W-1:0];
            end
        end
        for (int r = 1; r < tcpd_pkg::RING_COUNT; r++) utot += model_rings[r].size();
        rs.uwait = tcpd_pkg::UWAIT_W'(utot);
        rs.nwait = tcpd_pkg::NWAIT_W'(model_rings[0].size());
        return rs;
    endfunction

    function automatic void check_field(input string name, input longint unsigned exp_v,
                                        input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            lead_cnt <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_results.push_back(predict_dispatch(cur_req));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (req_fifo.size() != 0 && lead_cnt >= req_fifo[0].gap) begin
                    cur_req = req_fifo.pop_front();
                    s_tdata  <= tcpd_pkg::S_TDATA_W'({cur_req.level, cur_req.age,
                                                      cur_req.id});
                    s_tuser  <= cur_req.op;
                    s_tvalid <= 1'b1;
                    lead_cnt <= 0;
                end else begin
                    s_tvalid <= 1'b0;
                    if (req_fifo.size() != 0) lead_cnt <= lead_cnt + 1;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_mark <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((n_accepted == 100 || n_accepted == 400) && hold_mark != n_accepted) begin
            hold_left <= HOLD_CYCLES;
            hold_mark <= n_accepted;
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        m_word_t w;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                w = m_word_t'(m_tdata[$bits(m_word_t)-1:0]);
                got = '{status: m_tuser, sid: w.sid, sage: w.sage, slevel: w.slevel,
                        uwait: w.uwait, nwait: w.nwait};
                n_checked <= n_checked + 1;
                if (due_results.size() == 0) begin
                    $error("result word with nothing expected, status %0d", m_tuser);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("served_id", want.sid, got.sid);
                    check_field("served_age_bits", want.sage, got.sage);
                    check_field("served_level", want.slevel, got.slevel);
                    check_field("urgent_waiting", want.uwait, got.uwait);
                    check_field("normal_waiting", want.nwait, got.nwait);
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (sink_stall != 0) begin
                m_tready   <= 1'b0;
                sink_stall <= sink_stall - 1;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready && !(n_checked >= 150 && n_checked < 250))
                    sink_stall <= pick_gap();
            end
        end
    end

    function automatic logic [tcpd_pkg::ID_W-1:0] rand_id();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return tcpd_pkg::ID_W'($urandom);
        endcase
    endfunction

    function automatic logic [tcpd_pkg::AGE_W-1:0] rand_age();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input logic [tcpd_pkg::OP_W-1:0] op,
                           input logic [tcpd_pkg::ID_W-1:0] id,
                           input logic [tcpd_pkg::AGE_W-1:0] age,
                           input logic [tcpd_pkg::LEVEL_W-1:0] level,
                           input bit calm);
        req_t rq;
        rq.op    = op;
        rq.id    = id;
        rq.age   = age;
        rq.level = level;
        rq.gap   = calm ? 0 : pick_gap();
        req_fifo.push_back(rq);
    endtask

    task automatic random_burst(input int n, input int w_norm, input int w_urg,
                                input int focus, input bit calm);
        int unsigned r;
        logic [tcpd_pkg::OP_W-1:0]    op;
        logic [tcpd_pkg::LEVEL_W-1:0] lvl;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            lvl = tcpd_pkg::LEVEL_W'($urandom_range(0, 7));
            if (r < w_norm) begin
                op = tcpd_pkg::OP_ENQ_NORMAL;
            end else if (r < w_norm + w_urg) begin
                op = tcpd_pkg::OP_ENQ_URGENT;
                if (focus != 0 && $urandom_range(0, 9) != 0)
                    lvl = tcpd_pkg::LEVEL_W'(focus);
                else if ($urandom_range(0, 9) != 0)
                    lvl = tcpd_pkg::LEVEL_W'($urandom_range(1, tcpd_pkg::URGENCY_LEVELS));
            end else begin
                op = ($urandom_range(0, 9) == 0) ? OP_DEQUEUE_ALT : OP_DEQUEUE;
            end
            add_req(op, rand_id(), rand_age(), lvl, calm);
        end
    endtask

    initial begin
        // directed: empty dequeues, bad levels, extremes, priority order
        add_req(OP_DEQUEUE,              '0, '0, 3'd0, 1'b0);
        add_req(OP_DEQUEUE_ALT,          '1, '1, 3'd7, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, '1, '1, 3'd0, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, 31'h1, 32'h1, 3'd4, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, 31'h2, 32'h2, 3'd5, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, 31'h3, 32'h3, 3'd6, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, 31'h4, 32'h4, 3'd7, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_NORMAL, '0, '0, 3'd7, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_NORMAL, '1, '1, 3'd0, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, '1, '0, 3'd3, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, '0, '1, 3'd2, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, 31'h5555_5555, 32'hAAAA_AAAA, 3'd1, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, 31'h2AAA_AAAA, 32'h5555_5555, 3'd3, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_URGENT, 31'h1234_5678, 32'h3F80_0000, 3'd1, 1'b0);
        add_req(tcpd_pkg::OP_ENQ_NORMAL, 31'h0BAD_CAFE, 32'h7F80_0000, 3'd3, 1'b0);
        for (int i = 0; i < 8; i++)
            add_req((i % 3 == 2) ? OP_DEQUEUE_ALT : OP_DEQUEUE, '0, '0, 3'(i), 1'b0);
        add_req(OP_DEQUEUE, '1, '1, 3'd7, 1'b0);

        random_burst(60, 30, 30, 0, 1'b0);
        random_burst(160, 95, 0, 0, 1'b1);
        random_burst(40, 10, 10, 0, 1'b0);
        random_burst(170, 0, 95, 2, 1'b0);
        random_burst(40, 10, 10, 0, 1'b0);
        n_total = req_fifo.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted != n_total) @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
